@@ rtl/core/assert_macros.svh @@
// Assertion helpers for the permutation enumerator checker.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, sampled on clk, off during reset.
`define CHK_SAME(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("check failed: same-cycle implication");

// Next-cycle implication, sampled on clk, off during reset.
`define CHK_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("check failed: next-cycle implication");

`endif

@@ rtl/core/perm_enum_pkg.sv @@
package perm_enum_pkg;

    localparam int DEF_MAX_LEN = 8;
    localparam int IDX_W       = 3;
    localparam int BYTE_W      = 8;
    localparam int LEN_W       = 4;
    localparam int CHARS_W     = 64;
    localparam int IDXF_W      = 24;
    localparam int CNT_W       = 16;
    localparam int RES_W       = CHARS_W + IDXF_W + CNT_W;
    localparam int IN_W        = 8;
    localparam int CFG_IDX_W   = 2;
    localparam int CFG_DATA_W  = 64;

    localparam logic [CFG_IDX_W-1:0] REG_WORD_LENGTH = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_WORD_CHARS  = 2'd1;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_START,
        ST_SEARCH,
        ST_ADVANCE
    } state_t;

    // controller -> datapath
    typedef struct packed {
        logic clear;
        logic launch;
        logic push;
        logic pop;
        logic incr;
        logic found;
        logic fail;
    } cmd_t;

    // datapath -> controller
    typedef struct packed {
        logic valid;
        logic full;
        logic empty;
        logic top_last;
        logic exhausted;
        logic started;
    } status_t;

endpackage

@@ rtl/core/permutation_enumerator_top.sv @@
// Permutation enumerator: steps through all orderings of a word's positions.
// Config channel (cfg_valid/cfg_ready, always ready): index 0 word_length,
// index 1 word_chars. Any such write clears the search; write only when idle.
// Request channel (s_axis_*): one request asks for the next permutation;
// tdata[0] = restart starts over from the first one.
// Result channel (m_axis_*): exactly one result per request, carrying the
// chosen characters, positions and running solution number; tuser flags
// that the enumeration is exhausted (payload zero, number = total found).
// A request that finds the enumeration already done is answered from the
// start state; a permutation needs a search whose length is data dependent.
// The search sequencer does at most one push, pop or index increment per
// cycle, so cost grows with the backtracking needed. One request is in
// flight at a time; the next is accepted the cycle after the result is
// registered.
// A stalled receiver holds the result register; a new request is still
// taken, and its result waits in the sequencer until the register frees.
// Reset: length 1, characters zero, empty stack, count zero, no result.
module permutation_enumerator_top
    import perm_enum_pkg::*;
#(
    parameter int MAX_LEN = DEF_MAX_LEN
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    input  logic                  s_axis_tvalid,
    output logic                  s_axis_tready,
    input  logic [IN_W-1:0]       s_axis_tdata,   // [0] restart
    output logic                  m_axis_tvalid,
    input  logic                  m_axis_tready,
    output logic [RES_W-1:0]      m_axis_tdata,   // perm_chars, perm_indices, solution_number
    output logic                  m_axis_tuser    // done_res
);

    cmd_t             cmd;
    status_t          status;
    logic [RES_W-1:0] res_data;
    logic             res_done;
    logic             out_free;
    logic             load;

    logic             m_valid_reg;
    logic             m_valid_next;
    logic [RES_W-1:0] m_data_reg;
    logic             m_user_reg;

    assign cfg_ready = 1'b1;
    assign out_free  = !m_valid_reg || m_axis_tready;
    assign load      = cmd.found || cmd.fail;

    perm_enum_ctrl u_ctrl (
        .clk         (clk),
        .rst_n       (rst_n),
        .req_valid   (s_axis_tvalid),
        .req_restart (s_axis_tdata[0]),
        .out_free    (out_free),
        .status      (status),
        .req_ready   (s_axis_tready),
        .cmd         (cmd)
    );

    perm_enum_dp #(
        .MAX_LEN (MAX_LEN)
    ) u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_wr    (cfg_valid & cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cmd       (cmd),
        .status    (status),
        .res_data  (res_data),
        .res_done  (res_done)
    );

    always_comb
    begin
        m_valid_next = m_valid_reg;
        if (load)
        begin
            m_valid_next = 1'b1;
        end
        else if (m_axis_tready)
        begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_valid_reg <= 1'b0;
        end
        else
        begin
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            m_data_reg <= res_data;
            m_user_reg <= res_done;
        end
    end

    assign m_axis_tvalid = m_valid_reg;
    assign m_axis_tdata  = m_data_reg;
    assign m_axis_tuser  = m_user_reg;

endmodule

@@ rtl/core/perm_enum_ctrl.sv @@
module perm_enum_ctrl
    import perm_enum_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    req_valid,
    input  logic    req_restart,
    input  logic    out_free,
    input  status_t status,
    output logic    req_ready,
    output cmd_t    cmd
);

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (req_valid)
                begin
                    state_next = ST_START;
                end
            end
            ST_START:
            begin
                if (status.exhausted)
                begin
                    if (out_free)
                    begin
                        state_next = ST_IDLE;
                    end
                end
                else if (!status.started)
                begin
                    state_next = ST_SEARCH;
                end
                else
                begin
                    state_next = ST_ADVANCE;
                end
            end
            ST_SEARCH:
            begin
                if (!status.valid)
                begin
                    state_next = ST_ADVANCE;
                end
                else if (status.full && out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_ADVANCE:
            begin
                if (status.empty)
                begin
                    if (out_free)
                    begin
                        state_next = ST_IDLE;
                    end
                end
                else if (!status.top_last)
                begin
                    state_next = ST_SEARCH;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        cmd       = '0;
        req_ready = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                req_ready = 1'b1;
                cmd.clear = req_valid & req_restart;
            end
            ST_START:
            begin
                if (status.exhausted)
                begin
                    cmd.fail = out_free;
                end
                else if (!status.started)
                begin
                    cmd.launch = 1'b1;
                end
            end
            ST_SEARCH:
            begin
                if (status.valid)
                begin
                    if (status.full)
                    begin
                        cmd.found = out_free;
                    end
                    else
                    begin
                        cmd.push = 1'b1;
                    end
                end
            end
            ST_ADVANCE:
            begin
                if (status.empty)
                begin
                    cmd.fail = out_free;
                end
                else if (status.top_last)
                begin
                    cmd.pop = 1'b1;
                end
                else
                begin
                    cmd.incr = 1'b1;
                end
            end
            default:
            begin
                cmd = '0;
            end
        endcase
    end

endmodule

@@ rtl/core/perm_enum_dp.sv @@
module perm_enum_dp
    import perm_enum_pkg::*;
#(
    parameter int MAX_LEN = DEF_MAX_LEN
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_wr,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    input  cmd_t                  cmd,
    output status_t               status,
    output logic [RES_W-1:0]      res_data,
    output logic                  res_done
);

    localparam int HW = $clog2(MAX_LEN + 1);
    localparam int IW = (MAX_LEN > 1) ? $clog2(MAX_LEN) : 1;

    logic [LEN_W-1:0]   word_len_reg;
    logic [CHARS_W-1:0] word_chars_reg;
    logic [IDX_W-1:0]   stack_reg [MAX_LEN];
    logic [HW-1:0]      height_reg;
    logic [HW-1:0]      height_next;
    logic               started_reg;
    logic               started_next;
    logic [CNT_W-1:0]   count_reg;
    logic [CNT_W-1:0]   count_next;
    logic               exhausted_reg;
    logic               exhausted_next;

    logic               cfg_clear;
    logic [HW-1:0]      n_eff;
    logic [IW-1:0]      top_sel;
    logic [IDX_W-1:0]   top_val;
    logic               stack_ok;
    logic [CHARS_W-1:0] pack_chars;
    logic [IDXF_W-1:0]  pack_idx;

    assign cfg_clear = cfg_wr &&
        (cfg_index == REG_WORD_LENGTH || cfg_index == REG_WORD_CHARS);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            word_len_reg   <= LEN_W'(1);
            word_chars_reg <= '0;
        end
        else if (cfg_wr)
        begin
            if (cfg_index == REG_WORD_LENGTH)
            begin
                word_len_reg <= cfg_data[LEN_W-1:0];
            end
            else if (cfg_index == REG_WORD_CHARS)
            begin
                word_chars_reg <= cfg_data[CHARS_W-1:0];
            end
        end
    end

    // length 0 acts as 1, oversize clamps to MAX_LEN
    always_comb
    begin
        if (word_len_reg == '0)
        begin
            n_eff = HW'(1);
        end
        else if (word_len_reg > LEN_W'(MAX_LEN))
        begin
            n_eff = HW'(MAX_LEN);
        end
        else
        begin
            n_eff = HW'(word_len_reg);
        end
    end

    assign top_sel = IW'(height_reg - HW'(1));
    assign top_val = stack_reg[top_sel];

    always_comb
    begin
        stack_ok = 1'b1;
        for (int i = 0; i < MAX_LEN; i++)
        begin
            for (int j = i + 1; j < MAX_LEN; j++)
            begin
                if (HW'(j) < height_reg && stack_reg[i] == stack_reg[j])
                begin
                    stack_ok = 1'b0;
                end
            end
        end
    end

    assign status.valid     = stack_ok;
    assign status.full      = (height_reg >= n_eff);
    assign status.empty     = (height_reg == '0);
    assign status.top_last  = (HW'(top_val) >= n_eff - HW'(1));
    assign status.exhausted = exhausted_reg;
    assign status.started   = started_reg;

    // stack entries are written before they are read; no reset
    always_ff @(posedge clk)
    begin
        if (cmd.push)
        begin
            stack_reg[height_reg[IW-1:0]] <= '0;
        end
        else if (cmd.incr)
        begin
            stack_reg[top_sel] <= top_val + IDX_W'(1);
        end
    end

    always_comb
    begin
        height_next    = height_reg;
        started_next   = started_reg;
        count_next     = count_reg;
        exhausted_next = exhausted_reg;
        if (cmd.clear || cfg_clear)
        begin
            height_next    = '0;
            started_next   = 1'b0;
            count_next     = '0;
            exhausted_next = 1'b0;
        end
        else if (cmd.launch)
        begin
            started_next = 1'b1;
            height_next  = '0;
        end
        else if (cmd.push)
        begin
            height_next = height_reg + HW'(1);
        end
        else if (cmd.pop)
        begin
            height_next = height_reg - HW'(1);
        end
        else if (cmd.found)
        begin
            count_next = count_reg + CNT_W'(1);
        end
        else if (cmd.fail)
        begin
            exhausted_next = 1'b1;
            height_next    = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            height_reg    <= '0;
            started_reg   <= 1'b0;
            count_reg     <= '0;
            exhausted_reg <= 1'b0;
        end
        else
        begin
            height_reg    <= height_next;
            started_reg   <= started_next;
            count_reg     <= count_next;
            exhausted_reg <= exhausted_next;
        end
    end

    // gather the chosen characters; only used when the stack is full
    always_comb
    begin
        logic [IDX_W-1:0] p;
        pack_chars = '0;
        pack_idx   = '0;
        for (int k = 0; k < MAX_LEN; k++)
        begin
            p = stack_reg[k];
            if (HW'(k) < n_eff)
            begin
                pack_chars[BYTE_W*k +: BYTE_W] = word_chars_reg[BYTE_W*p +: BYTE_W];
                pack_idx[IDX_W*k +: IDX_W]     = p;
            end
        end
    end

    always_comb
    begin
        if (cmd.fail)
        begin
            res_data = {count_reg, IDXF_W'(0), CHARS_W'(0)};
            res_done = 1'b1;
        end
        else
        begin
            res_data = {count_reg + CNT_W'(1), pack_idx, pack_chars};
            res_done = 1'b0;
        end
    end

endmodule

@@ rtl/core/perm_enum_checker.sv @@
`include "assert_macros.svh"

module perm_enum_checker
    import perm_enum_pkg::*;
(
    input logic                  clk,
    input logic                  rst_n,
    input logic                  s_axis_tvalid,
    input logic                  s_axis_tready,
    input logic                  m_axis_tvalid,
    input logic                  m_axis_tready,
    input logic [RES_W-1:0]      m_axis_tdata,
    input logic                  m_axis_tuser
);

    // a held result is not dropped
    `CHK_NEXT(a_out_hold, m_axis_tvalid && !m_axis_tready, m_axis_tvalid)

    // one request in flight: ready drops right after a request is taken
    `CHK_NEXT(a_one_req, s_axis_tvalid && s_axis_tready, !s_axis_tready)

    // exhausted result carries no permutation
    `CHK_SAME(a_done_empty, m_axis_tvalid && m_axis_tuser,
              m_axis_tdata[CHARS_W+IDXF_W-1:0] == '0)

    // a real permutation always has a nonzero solution number
    `CHK_SAME(a_num_nonzero, m_axis_tvalid && !m_axis_tuser,
              m_axis_tdata[RES_W-1:CHARS_W+IDXF_W] != '0)

endmodule

bind permutation_enumerator_top perm_enum_checker u_perm_enum_checker (.*);
